// ===== design/md4sh_pkg.sv =====
// md4sh_pkg: shared types, constants and step tables for the MD4-style hash.
// No dependencies; used by every other file of the block except md4sh_if.
package md4sh_pkg;

  localparam int MAX_LENGTH_BITS = 31;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] K_ROUND2 = 32'h5a827999;
  localparam logic [31:0] K_ROUND3 = 32'h6ed9eba1;
  // floor(n * RECIP10 / 2^35) == n / 10 for every 32-bit n
  localparam logic [31:0] RECIP10 = 32'hcccccccd;
  localparam int BLOCK_BYTES = 64;
  localparam int STEPS = 48;

  typedef enum logic [1:0] {
    JOB_BLOCK,
    JOB_FINAL,
    JOB_FINAL_ZERO
  } job_kind_t;

  typedef struct packed {
    job_kind_t                   kind;
    logic [MAX_LENGTH_BITS-1:0]  length;
    logic [BLOCK_BYTES*8-1:0]    data;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // block word used by step i
  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] j;
    logic [3:0] r;
    j = i[3:0];
    r = j;
    case (i[5:4])
      2'd0: r = j;
      2'd1: r = {j[1:0], j[3:2]};
      default: r = {j[0], j[1], j[2], j[3]};
    endcase
    return r;
  endfunction

  function automatic logic [4:0] step_shift(input logic [5:0] i);
    logic [4:0] s;
    s = 5'd3;
    case (i[5:4])
      2'd0: begin
        case (i[1:0])
          2'd0: s = 5'd3;
          2'd1: s = 5'd7;
          2'd2: s = 5'd11;
          default: s = 5'd19;
        endcase
      end
      2'd1: begin
        case (i[1:0])
          2'd0: s = 5'd3;
          2'd1: s = 5'd5;
          2'd2: s = 5'd9;
          default: s = 5'd13;
        endcase
      end
      default: begin
        case (i[1:0])
          2'd0: s = 5'd3;
          2'd1: s = 5'd9;
          2'd2: s = 5'd11;
          default: s = 5'd15;
        endcase
      end
    endcase
    return s;
  endfunction

endpackage

// ===== design/md4sh_if.sv =====
// md4sh_if: valid/ready channel interfaces for message bytes and digest words.
// No dependencies.
interface md4sh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;
  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface md4sh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== design/md4sh_queue.sv =====
// md4sh_queue: two-entry job queue between the byte packer and the compressor.
// Depends on md4sh_pkg.
module md4sh_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  md4sh_pkg::job_t       push_job,
  input  logic                  pop,
  output md4sh_pkg::job_t       head_job,
  output md4sh_pkg::q_status_t  status
);

  md4sh_pkg::job_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head_job     = entry[rd_ptr];
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && status.full))
    else $error("push into full job queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && status.empty))
    else $error("pop from empty job queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("job queue count out of range");
`endif

endmodule

// ===== design/md4sh_front.sv =====
// md4sh_front: accepts message bytes, packs 64-byte blocks and queues jobs.
// Depends on md4sh_pkg and md4sh_if.
module md4sh_front #(
  parameter int LENGTH_BITS = 31
) (
  input  logic                 clk,
  input  logic                 rst,
  md4sh_in_if.sink             msg,
  input  md4sh_pkg::q_status_t q_status,
  output logic                 push,
  output md4sh_pkg::job_t      push_job
);

  localparam int BW = md4sh_pkg::BLOCK_BYTES * 8;

  logic [BW-1:0]          blk;
  logic [5:0]             pos;
  logic [LENGTH_BITS-1:0] len;

  logic                   accept;
  logic [BW-1:0]          blk_next;
  logic [5:0]             pos_next;
  logic [LENGTH_BITS-1:0] len_next;
  logic                   wrapped;
  logic [BW-1:0]          padded;

  assign msg.ready = !q_status.full;
  assign accept    = msg.valid && msg.ready;

  always_comb begin
    blk_next = blk;
    if (msg.has_byte) begin
      blk_next[pos*8 +: 8] = msg.data_byte;
    end
    pos_next = pos + {5'd0, msg.has_byte};
    len_next = len + {{(LENGTH_BITS-1){1'b0}}, msg.has_byte};
    wrapped  = msg.has_byte && (pos_next == 6'd0);
    // zero every slot from the next free position up
    padded = blk_next;
    for (int b = 0; b < md4sh_pkg::BLOCK_BYTES; b++) begin
      if (6'(b) >= pos_next) padded[b*8 +: 8] = 8'h00;
    end
  end

  assign push = accept && (wrapped || msg.end_of_message);

  always_comb begin
    push_job.length = md4sh_pkg::MAX_LENGTH_BITS'(len_next);
    if (wrapped) begin
      push_job.data = blk_next;
      push_job.kind = msg.end_of_message ? md4sh_pkg::JOB_FINAL_ZERO
                                         : md4sh_pkg::JOB_BLOCK;
    end else begin
      push_job.data = padded;
      push_job.kind = md4sh_pkg::JOB_FINAL;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) blk <= blk_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 6'd0;
      len <= '0;
    end else if (accept) begin
      if (msg.end_of_message) begin
        pos <= 6'd0;
        len <= '0;
      end else begin
        pos <= pos_next;
        len <= len_next;
      end
    end
  end

endmodule

// ===== design/md4sh_back.sv =====
// md4sh_back: runs the 48 compression steps, builds the length block, emits digest.
// Depends on md4sh_pkg and md4sh_if.
module md4sh_back (
  input  logic                 clk,
  input  logic                 rst,
  input  md4sh_pkg::job_t      head_job,
  input  md4sh_pkg::q_status_t q_status,
  output logic                 pop,
  md4sh_out_if.source          digest
);

  localparam int BW = md4sh_pkg::BLOCK_BYTES * 8;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_COMP, S_ADD, S_DIGA, S_DIGB, S_OUT
  } state_t;

  typedef enum logic [1:0] {PH_DATA, PH_ZERO, PH_LEN} phase_t;

  state_t                  state;
  phase_t                  phase;
  md4sh_pkg::job_kind_t    kind;
  logic [md4sh_pkg::MAX_LENGTH_BITS-1:0] len;
  logic [BW-1:0]           blk;
  logic [3:0][31:0]        chain;
  logic [31:0]             a, b, c, d;
  logic [5:0]              step;
  logic [31:0]             n;
  logic [63:0]             prod;
  logic [5:0]              dpos;
  logic [1:0]              k;
  logic                    out_valid;

  logic [31:0] f, wk, addk, sum, rot;
  logic [4:0]  s;
  logic [28:0] q;
  logic [31:0] q10;
  logic [31:0] rem;

  always_comb begin
    case (step[5:4])
      2'd0: begin
        f    = (b & c) | (~b & d);
        addk = 32'd0;
      end
      2'd1: begin
        f    = (b & c) | (b & d) | (c & d);
        addk = md4sh_pkg::K_ROUND2;
      end
      default: begin
        f    = b ^ c ^ d;
        addk = md4sh_pkg::K_ROUND3;
      end
    endcase
    wk  = blk[md4sh_pkg::msg_index(step)*32 +: 32];
    s   = md4sh_pkg::step_shift(step);
    sum = a + f + wk + addk;
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  always_comb begin
    q   = prod[63:35];
    q10 = {q, 3'b000} + {2'b00, q, 1'b0};
    rem = n - q10;
  end

  assign pop                = (state == S_IDLE) && !q_status.empty;
  assign digest.valid       = out_valid;
  assign digest.digest_word = chain[k];
  assign digest.word_index  = k;
  assign digest.last_word   = (k == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_DATA;
      kind      <= md4sh_pkg::JOB_BLOCK;
      chain     <= {md4sh_pkg::IV3, md4sh_pkg::IV2, md4sh_pkg::IV1, md4sh_pkg::IV0};
      step      <= 6'd0;
      k         <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_status.empty) begin
            blk   <= head_job.data;
            kind  <= head_job.kind;
            len   <= head_job.length;
            phase <= PH_DATA;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          a     <= chain[0];
          b     <= chain[1];
          c     <= chain[2];
          d     <= chain[3];
          step  <= 6'd0;
          state <= S_COMP;
        end
        S_COMP: begin
          a <= d;
          b <= rot;
          c <= b;
          d <= c;
          step <= step + 6'd1;
          if (step == 6'(md4sh_pkg::STEPS - 1)) state <= S_ADD;
        end
        S_ADD: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          if (kind == md4sh_pkg::JOB_BLOCK) begin
            state <= S_IDLE;
          end else if (phase == PH_LEN) begin
            k         <= 2'd0;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else if (phase == PH_DATA && kind == md4sh_pkg::JOB_FINAL_ZERO) begin
            blk   <= '0;
            phase <= PH_ZERO;
            state <= S_LOAD;
          end else begin
            blk   <= '0;
            n     <= 32'(len);
            dpos  <= 6'd63;
            phase <= PH_LEN;
            state <= S_DIGA;
          end
        end
        S_DIGA: begin
          prod  <= n * md4sh_pkg::RECIP10;
          state <= S_DIGB;
        end
        S_DIGB: begin
          blk[dpos*8 +: 8] <= {4'h3, rem[3:0]};
          n    <= {3'b000, q};
          dpos <= dpos - 6'd1;
          state <= (q == 29'd0) ? S_LOAD : S_DIGA;
        end
        S_OUT: begin
          if (digest.ready) begin
            if (k == 2'd3) begin
              out_valid <= 1'b0;
              chain <= {md4sh_pkg::IV3, md4sh_pkg::IV2, md4sh_pkg::IV1, md4sh_pkg::IV0};
              state <= S_IDLE;
            end else begin
              k <= k + 2'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/md4_style_hash_decimal_length_pad.sv =====
// md4_style_hash_decimal_length_pad: top level, byte packer -> job queue -> compressor.
// Depends on md4sh_pkg, md4sh_if, md4sh_front, md4sh_queue, md4sh_back.
//
//   channel  dir  transaction
//   msg      in   one byte slot: data_byte, has_byte, end_of_message
//   digest   out  one chaining word: digest_word, word_index, last_word
//
// The packer takes one transaction per cycle while the two-entry job queue has room.
// A queued 64-byte block passes through the compressor as pop, load, 48 steps and add.
// At message end: one or two padding blocks, then each decimal digit of the length
// (DIGA, DIGB), then the length block, then four digest words.
// Reset (rst, synchronous) restores the MD4 initial chaining words and empties the queue.
// A stalled digest port holds the compressor; the packer keeps filling until the queue is full.
module md4_style_hash_decimal_length_pad #(
  parameter int LENGTH_BITS = 31
) (
  input logic          clk,
  input logic          rst,
  md4sh_in_if.sink     msg,
  md4sh_out_if.source  digest
);

  logic                 push;
  logic                 pop;
  md4sh_pkg::job_t      push_job;
  md4sh_pkg::job_t      head_job;
  md4sh_pkg::q_status_t q_status;

  md4sh_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .msg      (msg),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  md4sh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .status   (q_status)
  );

  md4sh_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_job (head_job),
    .q_status (q_status),
    .pop      (pop),
    .digest   (digest)
  );

endmodule

// ===== dv/md4sh_scoreboard.sv =====
// md4sh_scoreboard: digest predictor and result checker for the MD4-style hash.
// Depends on md4sh_pkg for the initial chaining words and round constants.
`timescale 1ns / 100ps

package md4sh_tb_pkg;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  idx;
    logic        last;
  } digest_t;

  class md4sh_scoreboard;
    logic [31:0] chain[4];
    logic [31:0] blk[16];
    int unsigned pos;
    logic [30:0] msg_len;
    digest_t     pending_digests[$];
    int          errors;
    int          words_seen;
    int          messages;

    function new();
      errors = 0;
      words_seen = 0;
      messages = 0;
      restart();
    endfunction

    function void restart();
      chain[0] = md4sh_pkg::IV0;
      chain[1] = md4sh_pkg::IV1;
      chain[2] = md4sh_pkg::IV2;
      chain[3] = md4sh_pkg::IV3;
      foreach (blk[i]) blk[i] = '0;
      pos = 0;
      msg_len = '0;
    endfunction

    function void put_byte(int unsigned p, logic [7:0] b);
      blk[p[5:2]][p[1:0]*8 +: 8] = b;
    endfunction

    function logic [31:0] rotl(logic [31:0] x, int unsigned s);
      return (x << s) | (x >> (32 - s));
    endfunction

    function void compress();
      logic [31:0] v[4];
      logic [31:0] b, c, d, f, k, add;
      int unsigned j, t, s, w;
      int unsigned sh1[4] = '{3, 7, 11, 19};
      int unsigned sh2[4] = '{3, 5, 9, 13};
      int unsigned sh3[4] = '{3, 9, 11, 15};
      int unsigned r3w[16] = '{0, 8, 4, 12, 2, 10, 6, 14, 1, 9, 5, 13, 3, 11, 7, 15};
      v = chain;
      for (int i = 0; i < 48; i++) begin
        j = i % 16;
        t = (4 - (j % 4)) % 4;
        b = v[(t + 1) % 4];
        c = v[(t + 2) % 4];
        d = v[(t + 3) % 4];
        if (i < 16) begin
          f = (b & c) | (~b & d);
          w = j;
          add = '0;
          s = sh1[j % 4];
        end else if (i < 32) begin
          f = (b & c) | (b & d) | (c & d);
          w = ((j % 4) * 4 + j / 4) % 16;
          add = md4sh_pkg::K_ROUND2;
          s = sh2[j % 4];
        end else begin
          f = b ^ c ^ d;
          w = r3w[j];
          add = md4sh_pkg::K_ROUND3;
          s = sh3[j % 4];
        end
        k = blk[w];
        v[t] = rotl(v[t] + f + k + add, s);
      end
      for (int i = 0; i < 4; i++) chain[i] += v[i];
    endfunction

    // accepted input transaction
    function void note_byte_slot(logic [7:0] data, logic has, logic eom);
      int unsigned p;
      int unsigned n;
      if (has) begin
        put_byte(pos, data);
        pos = (pos + 1) % 64;
        msg_len = msg_len + 1;
        if (pos == 0) compress();
      end
      if (!eom) return;
      p = pos;
      do begin
        put_byte(p, 8'h00);
        p = (p + 1) % 64;
      end while (p != 0);
      compress();
      foreach (blk[i]) blk[i] = '0;
      n = msg_len;
      p = 63;
      do begin
        put_byte(p, 8'h30 + n % 10);
        n = n / 10;
        p--;
      end while (n != 0);
      compress();
      for (int i = 0; i < 4; i++)
        pending_digests.push_back('{chain[i], 2'(i), i == 3});
      messages++;
      restart();
    endfunction

    function void check_digest(logic [31:0] word, logic [1:0] idx, logic last);
      digest_t exp_d;
      words_seen++;
      if (pending_digests.size() == 0) begin
        $display("%0t: unexpected digest word %h idx %0d last %0b", $time, word, idx, last);
        errors++;
        return;
      end
      exp_d = pending_digests.pop_front();
      if (word !== exp_d.word)
        $display("%0t: digest_word expected %h actual %h", $time, exp_d.word, word);
      if (idx !== exp_d.idx)
        $display("%0t: word_index expected %0d actual %0d", $time, exp_d.idx, idx);
      if (last !== exp_d.last)
        $display("%0t: last_word expected %0b actual %0b", $time, exp_d.last, last);
      if (word !== exp_d.word || idx !== exp_d.idx || last !== exp_d.last) errors++;
    endfunction
  endclass
endpackage

// ===== dv/tb_md4_style_hash_decimal_length_pad.sv =====
// tb_md4_style_hash_decimal_length_pad: drives byte slots with random gaps and
// digest back-pressure; depends on md4sh_pkg, md4sh_if and dv/md4sh_scoreboard.sv.
`timescale 1ns / 100ps

module tb_md4_style_hash_decimal_length_pad;

  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic calm;
  int   cycles;
  int   slots_sent;

  md4sh_in_if  msg ();
  md4sh_out_if digest ();

  md4_style_hash_decimal_length_pad dut (
    .clk(clk), .rst(rst), .msg(msg.sink), .digest(digest.source)
  );

  md4sh_tb_pkg::md4sh_scoreboard sb;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    sb = new();
    cycles = 0;
    slots_sent = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_md4_style_hash_decimal_length_pad: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && msg.valid && msg.ready) begin
      sb.note_byte_slot(msg.data_byte, msg.has_byte, msg.end_of_message);
      slots_sent++;
    end
    if (!rst && digest.valid && digest.ready)
      sb.check_digest(digest.digest_word, digest.word_index, digest.last_word);
  end

  // digest back-pressure
  always @(negedge clk) begin
    if (rst) digest.ready <= 1'b0;
    else digest.ready <= calm || ($urandom_range(99) >= 27);
  end

  task automatic send_slot(logic [7:0] data, logic has, logic eom);
    while (!calm && $urandom_range(99) < 27) begin
      msg.valid <= 1'b0;
      @(negedge clk);
    end
    msg.valid <= 1'b1;
    msg.data_byte <= data;
    msg.has_byte <= has;
    msg.end_of_message <= eom;
    do @(posedge clk); while (!msg.ready);
    @(negedge clk);
  endtask

  task automatic send_message(int unsigned len, int mode);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      case (mode)
        0: b = $urandom_range(255);
        1: b = 8'hff;
        2: b = 8'h00;
        default: b = 8'(i);
      endcase
      // occasional empty slots inside the message
      if ($urandom_range(9) == 0) send_slot($urandom_range(255), 1'b0, 1'b0);
      if (i == len - 1 && $urandom_range(1)) begin
        send_slot(b, 1'b1, 1'b1);
        return;
      end
      send_slot(b, 1'b1, 1'b0);
    end
    send_slot($urandom_range(255), 1'b0, 1'b1);
  endtask

  task automatic drain();
    msg.valid <= 1'b0;
    while (sb.pending_digests.size() != 0) @(negedge clk);
  endtask

  initial begin
    int wait_cycles;
    rst = 1'b1;
    calm = 1'b0;
    msg.valid = 1'b0;
    msg.data_byte = '0;
    msg.has_byte = 1'b0;
    msg.end_of_message = 1'b0;
    digest.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty slots, empty message, short, block-full, bit toggles
    send_slot(8'hff, 1'b0, 1'b0);
    send_slot(8'h00, 1'b0, 1'b1);
    send_slot(8'hff, 1'b1, 1'b1);
    send_slot(8'h00, 1'b1, 1'b0);
    send_slot(8'h55, 1'b1, 1'b0);
    send_slot(8'haa, 1'b1, 1'b1);
    drain();
    send_message(64, 1);
    drain();
    send_message(9, 3);
    send_message(63, 2);

    // random messages; a calm stretch with no idling on either side
    while (slots_sent < 290) begin
      if (slots_sent > 150 && slots_sent < 220) calm = 1'b1;
      else calm = 1'b0;
      case ($urandom_range(5))
        0: send_message($urandom_range(1, 4), 0);
        1: send_message(64 * $urandom_range(1, 2), 0);
        2: send_message($urandom_range(60, 70), 0);
        default: send_message($urandom_range(1, 40), 0);
      endcase
      if ($urandom_range(5) == 0) drain();
    end
    calm = 1'b0;
    msg.valid <= 1'b0;

    wait_cycles = 0;
    while (sb.pending_digests.size() != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (300) @(negedge clk);
    $display("covered %0d byte slots, %0d messages, %0d digest words checked",
             slots_sent, sb.messages, sb.words_seen);
    if (sb.errors == 0 && sb.pending_digests.size() == 0)
      $display("tb_md4_style_hash_decimal_length_pad: PASS");
    else begin
      $display("errors %0d, words still expected %0d", sb.errors, sb.pending_digests.size());
      $display("tb_md4_style_hash_decimal_length_pad: FAIL");
    end
    $finish;
  end
endmodule
